>>> rtl/core/cdd_pkg.sv
// ----------------------------------------------------------------------------
// cdd_pkg
// Shared types and constants of the cursor dwell detector: request and event
// codes, hover modes, register indexes and the control word of the step logic.
// ----------------------------------------------------------------------------
package cdd_pkg;

	localparam int RADIUS_W = 10;
	localparam int DWELL_W  = 16;
	localparam int TIME_W   = 32;
	localparam int TAG_W    = 32;
	localparam int GENO_W   = 32;
	localparam int CFG_W    = 16;
	localparam int CFGI_W   = 1;

	localparam logic [RADIUS_W-1:0] RADIUS_RST = 10'd4;
	localparam logic [DWELL_W-1:0]  DWELL_RST  = 16'd500;

	localparam logic [CFGI_W-1:0] CFG_STABLE_RADIUS = 1'd0;
	localparam logic [CFGI_W-1:0] CFG_DWELL_TIME    = 1'd1;

	typedef enum logic [1:0] {
		REQ_SAMPLE = 2'd0,
		REQ_CANCEL = 2'd1,
		REQ_DONE   = 2'd2
	} req_t;

	typedef enum logic [2:0] {
		EV_NONE     = 3'd0,
		EV_CANCELED = 3'd1,
		EV_FIRED    = 3'd2,
		EV_PRESENT  = 3'd3,
		EV_STALE    = 3'd4
	} event_t;

	typedef enum logic [1:0] {
		MODE_IDLE    = 2'd0,
		MODE_PENDING = 2'd1,
		MODE_FIRED   = 2'd2
	} mode_t;

	// Decisions of the step logic for one item
	typedef struct packed {
		logic   load_point;  // store the sample as the last point
		logic   have_point;  // next value of the have-point flag
		mode_t  mode;        // next hover mode
		logic   bump_gen;    // advance the generation
		logic   load_since;  // capture time_ms as the stable start
		event_t ev;          // event code of the result
	} step_ctl_t;

endpackage

>>> rtl/core/cdd_step.sv
// ----------------------------------------------------------------------------
// cdd_step
// Decision logic for one item: radius checks, dwell timer compare and the
// generation tag compare, folded into a control word for the state registers.
// ----------------------------------------------------------------------------
module cdd_step #(
	parameter int COORD_BITS = 16,
	parameter int GEN_BITS   = 32
) (
	input  logic [1:0]                    req_type,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic [cdd_pkg::TIME_W-1:0]    time_ms,
	input  logic [cdd_pkg::TAG_W-1:0]     done_gen,
	input  logic                          have_point,
	input  logic signed [COORD_BITS-1:0]  last_x,
	input  logic signed [COORD_BITS-1:0]  last_y,
	input  cdd_pkg::mode_t                mode,
	input  logic [cdd_pkg::TIME_W-1:0]    stable_since,
	input  logic [GEN_BITS-1:0]           gen,
	input  logic [cdd_pkg::RADIUS_W-1:0]  stable_radius,
	input  logic [cdd_pkg::DWELL_W-1:0]   dwell_time,
	output cdd_pkg::step_ctl_t            ctl
);

	localparam int DW = COORD_BITS + 1;
	localparam int CW = (DW > cdd_pkg::RADIUS_W) ? DW : cdd_pkg::RADIUS_W;

	logic signed [DW-1:0]       dx, dy;
	logic [DW-1:0]              ax, ay;
	logic                       near;
	logic [cdd_pkg::TIME_W-1:0] elapsed;
	logic                       dwell_done;
	logic                       tag_match;

	assign dx = DW'(pos_x) - DW'(last_x);
	assign dy = DW'(pos_y) - DW'(last_y);
	assign ax = dx[DW-1] ? DW'(-dx) : DW'(dx);
	assign ay = dy[DW-1] ? DW'(-dy) : DW'(dy);
	assign near = (CW'(ax) <= CW'(stable_radius)) && (CW'(ay) <= CW'(stable_radius));

	assign elapsed    = time_ms - stable_since;
	assign dwell_done = elapsed >= cdd_pkg::TIME_W'(dwell_time);
	assign tag_match  = 64'(done_gen) == 64'(gen);

	always_comb begin
		ctl.load_point = 1'b0;
		ctl.have_point = have_point;
		ctl.mode       = mode;
		ctl.bump_gen   = 1'b0;
		ctl.load_since = 1'b0;
		ctl.ev         = cdd_pkg::EV_NONE;
		unique case (req_type)
			cdd_pkg::REQ_SAMPLE: begin
				ctl.load_point = 1'b1;
				ctl.have_point = 1'b1;
				if (!have_point || !near) begin
					// hover broken: back to idle, cancel an active hover
					ctl.mode = cdd_pkg::MODE_IDLE;
					if (mode != cdd_pkg::MODE_IDLE) begin
						ctl.bump_gen = 1'b1;
						ctl.ev       = cdd_pkg::EV_CANCELED;
					end
				end else if (mode == cdd_pkg::MODE_IDLE) begin
					ctl.bump_gen   = 1'b1;
					ctl.mode       = cdd_pkg::MODE_PENDING;
					ctl.load_since = 1'b1;
				end else if (mode == cdd_pkg::MODE_PENDING && dwell_done) begin
					ctl.mode = cdd_pkg::MODE_FIRED;
					ctl.ev   = cdd_pkg::EV_FIRED;
				end
			end
			cdd_pkg::REQ_CANCEL: begin
				ctl.have_point = 1'b0;
				ctl.mode       = cdd_pkg::MODE_IDLE;
				if (mode != cdd_pkg::MODE_IDLE) begin
					ctl.bump_gen = 1'b1;
					ctl.ev       = cdd_pkg::EV_CANCELED;
				end
			end
			cdd_pkg::REQ_DONE: begin
				ctl.ev = tag_match ? cdd_pkg::EV_PRESENT : cdd_pkg::EV_STALE;
			end
			default: begin
				// unused request code: no change, no event
				ctl.ev = cdd_pkg::EV_NONE;
			end
		endcase
	end

endmodule

>>> rtl/core/cursor_dwell_detector.sv
// ----------------------------------------------------------------------------
// cursor_dwell_detector
// Dwell detector for a pointer: tracks hover stability within a radius, fires
// after a dwell time, cancels broken hovers and screens probe completions by
// their generation tag.
// ----------------------------------------------------------------------------
// Usage:
//   Input channel (in_valid / in_stall) carries one item per request: a
//   pointer sample, a cancel request or a probe completion. Output channel
//   (out_valid / out_stall) returns exactly one result item per input item,
//   in order.
//   Flow: an accepted item sits in the input register while the step logic
//   runs; its result loads into the output register as soon as that register
//   is free (empty or being taken), and out_valid rises with the load.
//   Throughput: one item per cycle unless the output stalls. The only feedback
//   path is the hover state (point, mode, stable start, generation), updated in
//   the same cycle the item moves from the input to the output register.
//   Stall: while the receiver stalls a full output register, the input
//   register holds its item and in_stall rises once it is occupied.
//   Configuration: cfg_we with cfg_index writes stable_radius or dwell_time;
//   write only while no item is in flight.
//   Reset (arst_n low) empties both registers, forgets the point, returns to
//   idle, clears the generation and loads the register defaults.
// ----------------------------------------------------------------------------
module cursor_dwell_detector #(
	parameter int COORD_BITS = 16,
	parameter int GEN_BITS   = 32
) (
	input  logic                          clk,
	input  logic                          arst_n,
	// configuration
	input  logic                          cfg_we,
	input  logic [cdd_pkg::CFGI_W-1:0]    cfg_index,
	input  logic [cdd_pkg::CFG_W-1:0]     cfg_data,
	// input channel
	input  logic                          in_valid,
	output logic                          in_stall,
	input  logic [1:0]                    req_type,
	input  logic signed [COORD_BITS-1:0]  pos_x,
	input  logic signed [COORD_BITS-1:0]  pos_y,
	input  logic [cdd_pkg::TIME_W-1:0]    time_ms,
	input  logic [cdd_pkg::TAG_W-1:0]     done_gen,
	// output channel
	output logic                          out_valid,
	input  logic                          out_stall,
	output logic [2:0]                    event_res,
	output logic [cdd_pkg::GENO_W-1:0]    gen_out,
	output logic signed [COORD_BITS-1:0]  fire_x,
	output logic signed [COORD_BITS-1:0]  fire_y,
	output logic [cdd_pkg::TIME_W-1:0]    stable_start
);

	// configuration registers
	logic [cdd_pkg::RADIUS_W-1:0] radius_q;
	logic [cdd_pkg::DWELL_W-1:0]  dwell_q;

	// input register
	logic                          valid_s1;
	logic [1:0]                    req_s1;
	logic signed [COORD_BITS-1:0]  px_s1, py_s1;
	logic [cdd_pkg::TIME_W-1:0]    time_s1;
	logic [cdd_pkg::TAG_W-1:0]     tag_s1;

	// hover state
	logic                          have_point_q;
	logic signed [COORD_BITS-1:0]  last_x_q, last_y_q;
	cdd_pkg::mode_t                mode_q;
	logic [cdd_pkg::TIME_W-1:0]    since_q;
	logic [GEN_BITS-1:0]           gen_q;

	// result register
	logic                          out_valid_q;
	cdd_pkg::event_t               ev_q;
	logic [cdd_pkg::GENO_W-1:0]    gen_out_q;
	logic signed [COORD_BITS-1:0]  fx_q, fy_q;
	logic [cdd_pkg::TIME_W-1:0]    fs_q;

	cdd_pkg::step_ctl_t            ctl;
	logic                          out_free;
	logic                          advance;
	logic                          in_take;
	logic [GEN_BITS-1:0]           gen_d;
	logic                          fired;

	// The output register frees when empty or when its item is taken
	assign out_free = !out_valid_q || !out_stall;
	assign advance  = valid_s1 && out_free;
	assign in_stall = valid_s1 && !out_free;
	assign in_take  = in_valid && !in_stall;

	cdd_step #(
		.COORD_BITS (COORD_BITS),
		.GEN_BITS   (GEN_BITS)
	) u_step (
		.req_type      (req_s1),
		.pos_x         (px_s1),
		.pos_y         (py_s1),
		.time_ms       (time_s1),
		.done_gen      (tag_s1),
		.have_point    (have_point_q),
		.last_x        (last_x_q),
		.last_y        (last_y_q),
		.mode          (mode_q),
		.stable_since  (since_q),
		.gen           (gen_q),
		.stable_radius (radius_q),
		.dwell_time    (dwell_q),
		.ctl           (ctl)
	);

	assign gen_d = ctl.bump_gen ? gen_q + GEN_BITS'(1) : gen_q;
	assign fired = ctl.ev == cdd_pkg::EV_FIRED;

	// Configuration writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radius_q <= cdd_pkg::RADIUS_RST;
			dwell_q  <= cdd_pkg::DWELL_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				cdd_pkg::CFG_STABLE_RADIUS: radius_q <= cfg_data[cdd_pkg::RADIUS_W-1:0];
				cdd_pkg::CFG_DWELL_TIME:    dwell_q  <= cfg_data[cdd_pkg::DWELL_W-1:0];
				default: ;
			endcase
		end
	end

	// Input register: fill on accept, drop once the item advances
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_take) begin
			valid_s1 <= 1'b1;
		end else if (advance) begin
			valid_s1 <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (in_take) begin
			req_s1  <= req_type;
			px_s1   <= pos_x;
			py_s1   <= pos_y;
			time_s1 <= time_ms;
			tag_s1  <= done_gen;
		end
	end

	// Hover state: update as the item advances into the result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			have_point_q <= 1'b0;
			last_x_q     <= '0;
			last_y_q     <= '0;
			mode_q       <= cdd_pkg::MODE_IDLE;
			since_q      <= '0;
			gen_q        <= '0;
		end else if (advance) begin
			have_point_q <= ctl.have_point;
			mode_q       <= ctl.mode;
			gen_q        <= gen_d;
			if (ctl.load_point) begin
				last_x_q <= px_s1;
				last_y_q <= py_s1;
			end
			if (ctl.load_since) begin
				since_q <= time_s1;
			end
		end
	end

	// Result register: load on advance, empty when taken with nothing behind
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (advance) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (advance) begin
			ev_q      <= ctl.ev;
			gen_out_q <= cdd_pkg::GENO_W'(64'(gen_d));
			fx_q      <= fired ? px_s1 : '0;
			fy_q      <= fired ? py_s1 : '0;
			fs_q      <= fired ? since_q : '0;
		end
	end

	assign out_valid    = out_valid_q;
	assign event_res    = ev_q;
	assign gen_out      = gen_out_q;
	assign fire_x       = fx_q;
	assign fire_y       = fy_q;
	assign stable_start = fs_q;

endmodule

>>> rtl/core/cdd_checker.sv
// ----------------------------------------------------------------------------
// cdd_checker
// Port-level checks of the cursor dwell detector, bound to the top level.
// ----------------------------------------------------------------------------
module cdd_checker #(
	parameter int COORD_BITS = 16
) (
	input logic                          clk,
	input logic                          arst_n,
	input logic                          in_valid,
	input logic                          in_stall,
	input logic [1:0]                    req_type,
	input logic signed [COORD_BITS-1:0]  pos_x,
	input logic signed [COORD_BITS-1:0]  pos_y,
	input logic [cdd_pkg::TIME_W-1:0]    time_ms,
	input logic [cdd_pkg::TAG_W-1:0]     done_gen,
	input logic                          out_valid,
	input logic                          out_stall,
	input logic [2:0]                    event_res,
	input logic [cdd_pkg::GENO_W-1:0]    gen_out,
	input logic signed [COORD_BITS-1:0]  fire_x,
	input logic signed [COORD_BITS-1:0]  fire_y,
	input logic [cdd_pkg::TIME_W-1:0]    stable_start
);

	// Input backs up only behind a full, stalled output
	a_stall_cause: assert property (@(posedge clk) disable iff (!arst_n)
		in_stall |-> (out_valid && out_stall))
		else $error("in_stall without a stalled result");

	// Fire fields are zero on every result that is not a dwell fire
	a_fire_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && event_res != cdd_pkg::EV_FIRED) |->
		(fire_x == '0 && fire_y == '0 && stable_start == '0))
		else $error("fire fields set on a non-fire result");

	// Event codes stay within the defined set
	a_event_range: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (event_res <= 3'(cdd_pkg::EV_STALE)))
		else $error("undefined event code");

	// A stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid && out_stall) |=> (out_valid && $stable(event_res) && $stable(gen_out)))
		else $error("stalled result changed");

	// A stalled input item holds until taken
	a_in_hold: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && in_stall) |=> (in_valid && $stable(req_type) && $stable(pos_x) &&
		$stable(pos_y) && $stable(time_ms) && $stable(done_gen)))
		else $error("stalled input item changed");

endmodule

bind cursor_dwell_detector cdd_checker #(
	.COORD_BITS (COORD_BITS)
) u_cdd_checker (.*);
